// ----- src/ntt_pkg.sv -----
// shared constants, types and twiddle table for the mod-p transform
`default_nettype none
package ntt_pkg;

   localparam int MAX_LEN     = 64;
   localparam int LOG_MAX     = $clog2(MAX_LEN);
   localparam int STAGE_W     = $clog2(LOG_MAX + 1);
   localparam int CFG_LEN_W   = 3;
   localparam int COEF_W      = 30;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam logic [63:0] P_WIDE  = 64'd998244353;
   localparam logic [63:0] ROOT    = 64'd3;
   localparam logic [COEF_W-1:0] P_MOD = COEF_W'(P_WIDE);
   // barrett factor floor(2^60 / p)
   localparam logic [63:0] MU_WIDE = (64'd1 << 60) / P_WIDE;
   localparam logic [30:0] MU      = MU_WIDE[30:0];

   localparam logic [0:0] REG_LENGTH_LOG   = 1'd0;
   localparam logic [0:0] REG_INVERSE_MODE = 1'd1;

   typedef logic [COEF_W-1:0] twiddle_table_type [MAX_LEN];

   typedef struct packed {
      logic [LOG_MAX-1:0] addr;
      logic [COEF_W-1:0]  coef;
      logic               last;
      logic [STAGE_W-1:0] lg;
      logic               inv;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } head_type;

   typedef enum logic [3:0] {
      B_IDLE, B_RD, B_MUL, B_BQ, B_BQP, B_BR1, B_BR2, B_WS, B_WD, B_OUT
   } state_type;

   function automatic twiddle_table_type build_twiddles();
      twiddle_table_type t;
      logic [63:0] g;
      logic [63:0] b;
      logic [63:0] e;
      logic [63:0] acc;
      g = 64'd1;
      b = ROOT;
      e = (P_WIDE - 64'd1) / MAX_LEN;
      for (int j = 0; j < 64; j++) begin
         if (e[j]) begin
            g = (g * b) % P_WIDE;
         end
         b = (b * b) % P_WIDE;
      end
      acc = 64'd1;
      for (int i = 0; i < MAX_LEN; i++) begin
         t[i] = COEF_W'(acc);
         acc  = (acc * g) % P_WIDE;
      end
      return t;
   endfunction

   localparam twiddle_table_type TWIDDLE = build_twiddles();

endpackage
`default_nettype wire

// ----- src/ntt_forward_inverse_mod_p.sv -----
// top level of the radix-2 number theoretic transform modulo 998244353
// Radix-2 NTT mod p = 998244353 (root 3), forward or inverse, n = 2^length_log points
// (length_log clamped to 6, so up to 64 points). Coefficients arrive one per beat on
// req_, are reduced mod p and queued; the front end takes one beat per cycle while the
// four-entry queue has room. The back end drains the queue into the coefficient store at
// bit-reversed addresses (inverse mode reverses indices 1..n-1), one beat per cycle.
// After the n-th beat it runs n*log2(n)/2 butterflies through one shared modular
// multiplier (30x30 product and barrett reduction), then emits the n results in natural
// order, each scaled by 1 or n^-1 through the same multiplier and held through any
// receiver stall, tlast on the final one. The back end drains no new beats until the
// last result is loaded into the result register, while the queue holds up to four.
// Writing either csr register discards a partial load; write only while the block is idle.
`default_nettype none
module ntt_forward_inverse_mod_p import ntt_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   // input beats
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [31:0]          req_tdata,   // [29:0] coefficient, rest zero
   // result beats
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [31:0]               rsp_tdata,   // [29:0] value, rest zero
   output logic                      rsp_tlast,   // last_value
   // configuration writes: 0 length_log, 1 inverse_mode
   input  wire logic                 csr_we,
   input  wire logic [0:0]           csr_addr,
   input  wire logic [CFG_LEN_W-1:0] csr_wdata
);
   head_type head;
   logic     pop;

   // front end: reduction, addressing, queue
   ntt_front u_front (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata),
      .head(head), .pop(pop)
   );

   // back end: store, butterflies, result register
   ntt_back u_back (
      .clock(clock), .reset(reset),
      .head(head), .pop(pop),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast)
   );
endmodule
`default_nettype wire

// ----- src/ntt_ram.sv -----
// generic single-write ram with registered read
`default_nettype none
module ntt_ram #(
   parameter int WIDTH = 30,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire

// ----- src/ntt_front.sv -----
// input side: reduce, bit-reverse addressing and a short queue to the back end
`default_nettype none
module ntt_front import ntt_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [31:0]          req_tdata,
   input  wire logic                 csr_we,
   input  wire logic [0:0]           csr_addr,
   input  wire logic [CFG_LEN_W-1:0] csr_wdata,
   output head_type                  head,
   input  wire logic                 pop
);
   logic [CFG_LEN_W-1:0] len_ff, len_in;
   logic                 inv_ff, inv_in;
   logic [LOG_MAX-1:0]   cnt_ff, cnt_in;
   entry_type            q_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [QPTR_W:0]      fill_ff, fill_in;

   logic [STAGE_W-1:0] lg;
   logic [LOG_MAX:0]   n_w;
   logic [LOG_MAX-1:0] nm1, pos, rev;
   logic [COEF_W-1:0]  c;
   logic               push;
   entry_type          new_entry;

   always_comb begin
      lg  = (STAGE_W'(len_ff) > STAGE_W'(LOG_MAX)) ? STAGE_W'(LOG_MAX) : STAGE_W'(len_ff);
      n_w = (LOG_MAX + 1)'(1) << lg;
      nm1 = LOG_MAX'(n_w - (LOG_MAX + 1)'(1));
      pos = (inv_ff && cnt_ff != '0) ? LOG_MAX'(n_w - {1'b0, cnt_ff}) : cnt_ff;
      for (int i = 0; i < LOG_MAX; i++) begin
         rev[i] = pos[LOG_MAX-1-i];
      end
      c = (req_tdata[COEF_W-1:0] >= P_MOD) ? req_tdata[COEF_W-1:0] - P_MOD
                                           : req_tdata[COEF_W-1:0];
      new_entry.addr = rev >> (STAGE_W'(LOG_MAX) - lg);
      new_entry.coef = c;
      new_entry.last = (cnt_ff == nm1);
      new_entry.lg   = lg;
      new_entry.inv  = inv_ff;
   end

   assign req_tready = (fill_ff != (QPTR_W + 1)'(QUEUE_DEPTH));
   assign push       = req_tvalid && req_tready;
   assign head.valid = (fill_ff != '0);
   assign head.entry = q_ff[rd_ff];

   always_comb begin
      len_in  = len_ff;
      inv_in  = inv_ff;
      cnt_in  = cnt_ff;
      if (push) begin
         cnt_in = new_entry.last ? '0 : cnt_ff + LOG_MAX'(1);
      end
      if (csr_we) begin
         cnt_in = '0;
         case (csr_addr)
            REG_LENGTH_LOG:   len_in = csr_wdata;
            REG_INVERSE_MODE: inv_in = csr_wdata[0];
            default:          ;
         endcase
      end
      wr_in   = push ? wr_ff + QPTR_W'(1) : wr_ff;
      rd_in   = (pop && head.valid) ? rd_ff + QPTR_W'(1) : rd_ff;
      fill_in = fill_ff + (QPTR_W + 1)'(push) - (QPTR_W + 1)'(pop && head.valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff  <= CFG_LEN_W'(6);
         inv_ff  <= 1'b0;
         cnt_ff  <= '0;
         wr_ff   <= '0;
         rd_ff   <= '0;
         fill_ff <= '0;
      end else begin
         len_ff  <= len_in;
         inv_ff  <= inv_in;
         cnt_ff  <= cnt_in;
         wr_ff   <= wr_in;
         rd_ff   <= rd_in;
         fill_ff <= fill_in;
      end
      if (push) begin
         q_ff[wr_ff] <= new_entry;
      end
   end
endmodule
`default_nettype wire

// ----- src/ntt_back.sv -----
// back end: coefficient store, butterfly sequencer, barrett multiplier, result register
`default_nettype none
module ntt_back import ntt_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire head_type head,
   output logic       pop,
   output logic       rsp_tvalid,
   input  wire logic  rsp_tready,
   output logic [31:0] rsp_tdata,
   output logic       rsp_tlast
);
   state_type state_ff, state_in;
   logic [STAGE_W-1:0] lg_ff, lg_in, stage_ff, stage_in;
   logic               inv_ff, inv_in, outph_ff, outph_in;
   logic [LOG_MAX-2:0] bfly_ff, bfly_in;
   logic [LOG_MAX-1:0] idx_ff, idx_in;
   logic [COEF_W-1:0]  x_ff, red_ff;
   logic [59:0]        prod_ff;
   logic [61:0]        q2_ff;
   logic [31:0]        qp_ff, r_ff;
   logic               ovalid_ff, ovalid_in, olast_ff;
   logic [COEF_W-1:0]  odata_ff;

   logic [LOG_MAX-1:0] kmask, k, xa, ya, tw_idx, nm1, ra1;
   logic [LOG_MAX-2:0] hm1;
   logic [COEF_W-1:0]  rd0, rd1, scale, mul_b, sum_v, dif_v, wdata;
   logic [30:0]        s31, d31;
   logic [31:0]        r1;
   logic [60:0]        qp_full;
   logic [LOG_MAX-1:0] waddr;
   logic               we, out_free, oload;

   // butterfly addressing for stage s: x = group<<(s+1) | k, y = x | 2^s
   always_comb begin
      kmask  = (LOG_MAX'(1) << stage_ff) - LOG_MAX'(1);
      k      = {1'b0, bfly_ff} & kmask;
      xa     = LOG_MAX'((({1'b0, bfly_ff} >> stage_ff) << (stage_ff + STAGE_W'(1)))) | k;
      ya     = xa | (LOG_MAX'(1) << stage_ff);
      tw_idx = LOG_MAX'(k << (STAGE_W'(LOG_MAX - 1) - stage_ff));
      nm1    = LOG_MAX'(((LOG_MAX + 1)'(1) << lg_ff) - (LOG_MAX + 1)'(1));
      hm1    = (LOG_MAX - 1)'((LOG_MAX'(1) << lg_ff) >> 1) - (LOG_MAX - 1)'(1);
      scale  = inv_ff ? P_MOD - ((P_MOD - COEF_W'(1)) >> lg_ff) : COEF_W'(1);
      mul_b  = outph_ff ? scale : TWIDDLE[tw_idx];
      ra1    = outph_ff ? idx_ff : ya;
      s31    = {1'b0, x_ff} + {1'b0, red_ff};
      sum_v  = (s31 >= {1'b0, P_MOD}) ? COEF_W'(s31 - {1'b0, P_MOD}) : COEF_W'(s31);
      d31    = (x_ff >= red_ff) ? {1'b0, x_ff} - {1'b0, red_ff}
                                : {1'b0, x_ff} + {1'b0, P_MOD} - {1'b0, red_ff};
      dif_v  = COEF_W'(d31);
      qp_full = q2_ff[61:31] * P_MOD;
      r1     = (r_ff >= {2'b0, P_MOD}) ? r_ff - {2'b0, P_MOD} : r_ff;
      out_free = !ovalid_ff || rsp_tready;
   end

   // two copies of the store give two reads per cycle
   ntt_ram #(.WIDTH(COEF_W), .DEPTH(MAX_LEN)) u_ram0 (
      .clock(clock), .we(we), .waddr(waddr), .wdata(wdata), .raddr(xa), .rdata(rd0)
   );
   ntt_ram #(.WIDTH(COEF_W), .DEPTH(MAX_LEN)) u_ram1 (
      .clock(clock), .we(we), .waddr(waddr), .wdata(wdata), .raddr(ra1), .rdata(rd1)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         B_IDLE: if (head.valid && head.entry.last) state_in = B_RD;
         B_RD:   state_in = B_MUL;
         B_MUL:  state_in = B_BQ;
         B_BQ:   state_in = B_BQP;
         B_BQP:  state_in = B_BR1;
         B_BR1:  state_in = B_BR2;
         B_BR2:  state_in = outph_ff ? B_OUT : B_WS;
         B_WS:   state_in = B_WD;
         B_WD:   state_in = B_RD;
         B_OUT: begin
            if (out_free) begin
               state_in = (idx_ff == nm1) ? B_IDLE : B_RD;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   // outputs and counters
   always_comb begin
      pop      = 1'b0;
      we       = 1'b0;
      waddr    = xa;
      wdata    = sum_v;
      oload    = 1'b0;
      lg_in    = lg_ff;
      inv_in   = inv_ff;
      outph_in = outph_ff;
      stage_in = stage_ff;
      bfly_in  = bfly_ff;
      idx_in   = idx_ff;
      case (state_ff)
         B_IDLE: begin
            pop   = head.valid;
            we    = head.valid;
            waddr = head.entry.addr;
            wdata = head.entry.coef;
            if (head.valid && head.entry.last) begin
               lg_in    = head.entry.lg;
               inv_in   = head.entry.inv;
               outph_in = (head.entry.lg == '0);
               stage_in = '0;
               bfly_in  = '0;
               idx_in   = '0;
            end
         end
         B_WS: begin
            we = 1'b1;
         end
         B_WD: begin
            we    = 1'b1;
            waddr = ya;
            wdata = dif_v;
            if (bfly_ff == hm1) begin
               bfly_in = '0;
               if (stage_ff == lg_ff - STAGE_W'(1)) begin
                  outph_in = 1'b1;
               end else begin
                  stage_in = stage_ff + STAGE_W'(1);
               end
            end else begin
               bfly_in = bfly_ff + (LOG_MAX - 1)'(1);
            end
         end
         B_OUT: begin
            if (out_free) begin
               oload  = 1'b1;
               idx_in = idx_ff + LOG_MAX'(1);
            end
         end
         default: ;
      endcase
      ovalid_in = oload ? 1'b1 : (rsp_tready ? 1'b0 : ovalid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= B_IDLE;
         ovalid_ff <= 1'b0;
         lg_ff     <= '0;
         inv_ff    <= 1'b0;
         outph_ff  <= 1'b0;
         stage_ff  <= '0;
         bfly_ff   <= '0;
         idx_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         ovalid_ff <= ovalid_in;
         lg_ff     <= lg_in;
         inv_ff    <= inv_in;
         outph_ff  <= outph_in;
         stage_ff  <= stage_in;
         bfly_ff   <= bfly_in;
         idx_ff    <= idx_in;
      end
      if (state_ff == B_MUL) begin
         x_ff    <= rd0;
         prod_ff <= rd1 * mul_b;
      end
      q2_ff  <= prod_ff[59:29] * MU;
      qp_ff  <= qp_full[31:0];
      r_ff   <= prod_ff[31:0] - qp_ff;
      red_ff <= COEF_W'((r1 >= {2'b0, P_MOD}) ? r1 - {2'b0, P_MOD} : r1);
      if (oload) begin
         odata_ff <= red_ff;
         olast_ff <= (idx_ff == nm1);
      end
   end

   assign rsp_tvalid = ovalid_ff;
   assign rsp_tdata  = {2'b00, odata_ff};
   assign rsp_tlast  = olast_ff;
endmodule
`default_nettype wire

// ----- src/ntt_checker.sv -----
// port-level checks for the transform block and their binding
`default_nettype none
module ntt_checker import ntt_pkg::*; (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [31:0] rsp_tdata,
   input wire logic        rsp_tlast
);
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid && req_tready)
      else $error("outputs not idle after reset");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result changed");
   a_reduced: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[29:0] < P_MOD && rsp_tdata[31:30] == 2'b00)
      else $error("result not fully reduced");
endmodule

bind ntt_forward_inverse_mod_p ntt_checker u_ntt_checker (
   .clock(clock), .reset(reset), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast)
);
`default_nettype wire
